[hdl/ddo_pkg.sv]
// Shared types, constants and the arctangent lookup function for the odometry block.
`default_nettype none
package ddo_pkg;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 112;
  localparam int MODE_W     = 2;
  localparam int IPD_W      = 24;
  localparam int STEP_W     = 5;

  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ORIGIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd2;

  localparam logic [IPD_W-1:0] IPD_RESET = 24'd258830;

  // Bearing angles in Q.8 degrees
  localparam logic signed [17:0] FULL_TURN    = 18'sd92160;
  localparam logic signed [17:0] HALF_TURN    = 18'sd46080;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd23040;
  // 2^31 mod FULL_TURN, offset of the biased bearing
  localparam logic signed [17:0] BIAS_REM     = 18'sd63488;

  localparam logic signed [35:0] DEG_TO_RAD_Q40 = 36'sd19190098068;
  localparam logic signed [32:0] CORDIC_GAIN    = 33'sd652032874;

  localparam logic signed [32:0] ATAN_HEAD [10] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159, 33'sd67021687,
    33'sd33543516,  33'sd16775851,  33'sd8388437,   33'sd4194283,   33'sd2097149
  };

  function automatic logic signed [32:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [32:0] v;
    if (i < 5'd10) begin
      v = ATAN_HEAD[i[3:0]];
    end else if (i <= 5'd30) begin
      v = 33'sd1 <<< (5'd30 - i);
    end else begin
      v = '0;
    end
    return v;
  endfunction

  typedef struct packed {
    logic              load;
    logic              red;
    logic [2:0]        red_idx;
    logic              fold;
    logic              angle;
    logic              rotate;
    logic [STEP_W-1:0] step;
    logic              prod_lo;
    logic              prod_hi;
    logic              prod_sum;
    logic              accum;
    logic              apply;
    logic              load_out;
  } ddo_cmd_t;

endpackage
`default_nettype wire

[hdl/differential_drive_odometry.sv]
// Top level of the dead-reckoning odometry block.
// Takes one request at a time. A sample request (mode 0) reduces the bearing modulo a full
// turn, folds it, converts it to radians, runs the shared CORDIC stage, forms the rounded
// products and updates X and Y, loads the output register and then takes the next request.
// Reset-to-origin, set-coordinates and the unused mode go straight to the update step and
// then load the output register. The result sits in an output register, so a new request is
// taken while the previous result still waits; a request only stalls at its end if the
// previous result has not been taken yet.
`default_nettype none
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire  [23:0]  cfg_wdata,   // inch_per_degree
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [175:0] s_tdata,     // left_position, right_position, heading_degrees, new_x, new_y
  input  wire  [1:0]   s_tuser,     // mode
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [111:0] m_tdata      // x_position, y_position, last_heading
);
  import ddo_pkg::*;

  ddo_cmd_t cmd;
  logic     out_free;

  ddo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tuser),
    .out_free (out_free),
    .cmd      (cmd)
  );

  ddo_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .in_mode   (s_tuser),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in progress");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load_out))
    else $error("result valid without a result load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.red, cmd.fold, cmd.angle, cmd.rotate, cmd.prod_lo,
              cmd.prod_hi, cmd.prod_sum, cmd.accum, cmd.apply, cmd.load_out}))
    else $error("more than one datapath phase commanded");

endmodule
`default_nettype wire

[hdl/ddo_ctrl.sv]
// Sequencing state machine for the odometry datapath.
`default_nettype none
module ddo_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire [ddo_pkg::MODE_W-1:0]   mode,
  input  wire                         out_free,
  output ddo_pkg::ddo_cmd_t           cmd
);
  import ddo_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_REDUCE   = 11'b000_0000_0010,
    S_FOLD     = 11'b000_0000_0100,
    S_ANGLE    = 11'b000_0000_1000,
    S_ROTATE   = 11'b000_0001_0000,
    S_PROD_LO  = 11'b000_0010_0000,
    S_PROD_HI  = 11'b000_0100_0000,
    S_PROD_SUM = 11'b000_1000_0000,
    S_ACCUM    = 11'b001_0000_0000,
    S_APPLY    = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  state_t            state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (mode == MODE_SAMPLE) begin
            state_next = S_REDUCE;
            cnt_next   = STEP_W'(7);
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_REDUCE: begin
        if (cnt == '0) begin
          state_next = S_FOLD;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_FOLD:  state_next = S_ANGLE;
      S_ANGLE: begin
        state_next = S_ROTATE;
        cnt_next   = '0;
      end
      S_ROTATE: begin
        if (cnt == LAST_STEP) begin
          state_next = S_PROD_LO;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_PROD_LO:  state_next = S_PROD_HI;
      S_PROD_HI:  state_next = S_PROD_SUM;
      S_PROD_SUM: state_next = S_ACCUM;
      S_ACCUM:    state_next = S_FINISH;
      S_APPLY:    state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && s_tvalid;
    cmd.red      = (state == S_REDUCE);
    cmd.red_idx  = cnt[2:0];
    cmd.fold     = (state == S_FOLD);
    cmd.angle    = (state == S_ANGLE);
    cmd.rotate   = (state == S_ROTATE);
    cmd.step     = cnt;
    cmd.prod_lo  = (state == S_PROD_LO);
    cmd.prod_hi  = (state == S_PROD_HI);
    cmd.prod_sum = (state == S_PROD_SUM);
    cmd.accum    = (state == S_ACCUM);
    cmd.apply    = (state == S_APPLY);
    cmd.load_out = (state == S_FINISH) && out_free;
  end

endmodule
`default_nettype wire

[hdl/ddo_datapath.sv]
// Odometry datapath: distance, bearing reduction, CORDIC, products and result register.
`default_nettype none
module ddo_datapath (
  input  wire                             clk,
  input  wire                             rst,
  input  ddo_pkg::ddo_cmd_t               cmd,
  input  wire                             cfg_we,
  input  wire [ddo_pkg::IPD_W-1:0]        cfg_wdata,
  input  wire [ddo_pkg::IN_DATA_W-1:0]    in_data,
  input  wire [ddo_pkg::MODE_W-1:0]       in_mode,
  output logic                            out_free,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [ddo_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import ddo_pkg::*;

  function automatic logic [31:0] red_step(input logic [31:0] r, input logic [3:0] k);
    logic [32:0] c;
    c = 33'(FULL_TURN) << k;
    return ({1'b0, r} >= c) ? 32'({1'b0, r} - c) : r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [49:0] v);
    logic signed [39:0] s;
    if (v[49:39] == '0 || v[49:39] == '1) begin
      s = v[39:0];
    end else if (v[49]) begin
      s = {1'b1, {39{1'b0}}};
    end else begin
      s = {1'b0, {39{1'b1}}};
    end
    return s;
  endfunction

  logic [IPD_W-1:0] ipd;

  logic signed [31:0] prev_left, prev_right, held_heading;
  logic signed [39:0] pos_x, pos_y;

  logic        [MODE_W-1:0] req_mode;
  logic signed [31:0]       req_left, req_right, req_heading;
  logic signed [39:0]       req_new_x, req_new_y;

  logic signed [31:0] port_left, port_right, port_heading;
  logic signed [33:0] sum_reg, sum_next;
  logic        [31:0] red_rem, red_mid, red_out;
  logic signed [58:0] dist_prod, dist_round;
  logic signed [44:0] distance;

  logic signed [17:0] fold_ang, fold_next, m_a, m_b, m_c;
  logic               neg, neg_next;
  logic signed [53:0] ang_prod, ang_round;

  logic signed [32:0] cx, cy, cz, xs, ys, at;

  logic signed [22:0] op_a;
  logic signed [55:0] mul_x, mul_y, plo_x, plo_y, phi_x, phi_y;
  logic signed [55:0] rnd_x, rnd_y;
  logic signed [33:0] t_x, t_y;
  logic signed [56:0] s_x, s_y;
  logic signed [48:0] q_x, q_y;
  logic signed [49:0] acc_x, acc_y;

  logic signed [39:0] out_x, out_y;
  logic signed [31:0] out_h;

  assign port_left    = in_data[31:0];
  assign port_right   = in_data[63:32];
  assign port_heading = in_data[95:64];

  always_ff @(posedge clk) begin
    if (rst) begin
      ipd <= IPD_RESET;
    end else if (cfg_we) begin
      ipd <= cfg_wdata;
    end
  end

  // hold the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode    <= in_mode;
      req_left    <= port_left;
      req_right   <= port_right;
      req_heading <= port_heading;
      req_new_x   <= in_data[135:96];
      req_new_y   <= in_data[175:136];
      sum_reg     <= sum_next;
    end
  end

  assign sum_next = (34'(port_left) - 34'(prev_left)) + (34'(port_right) - 34'(prev_right));

  // bearing remainder, two divisor multiples per cycle
  assign red_mid = red_step(red_rem, {cmd.red_idx, 1'b1});
  assign red_out = red_step(red_mid, {cmd.red_idx, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red_rem <= {~port_heading[31], port_heading[30:0]};
    end else if (cmd.red) begin
      red_rem <= red_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.red) begin
      dist_prod <= sum_reg * $signed({1'b0, ipd});
    end
  end

  assign dist_round = dist_prod + 59'sd4096;

  always_ff @(posedge clk) begin
    if (cmd.fold) begin
      distance <= dist_round[57:13];
    end else if (cmd.angle && neg) begin
      distance <= -distance;
    end
  end

  // fold the bearing into a quarter turn either side of zero
  always_comb begin
    m_a = $signed({1'b0, red_rem[16:0]}) - BIAS_REM;
    m_b = m_a[17] ? m_a + FULL_TURN : m_a;
    m_c = (m_b > HALF_TURN) ? m_b - FULL_TURN : m_b;
    if (m_c > QUARTER_TURN) begin
      fold_next = m_c - HALF_TURN;
      neg_next  = 1'b1;
    end else if (m_c < -QUARTER_TURN) begin
      fold_next = m_c + HALF_TURN;
      neg_next  = 1'b1;
    end else begin
      fold_next = m_c;
      neg_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold) begin
      fold_ang <= fold_next;
      neg      <= neg_next;
    end
  end

  assign ang_prod  = fold_ang * DEG_TO_RAD_Q40;
  assign ang_round = ang_prod + 54'sd131072;

  assign xs = cx >>> cmd.step;
  assign ys = cy >>> cmd.step;
  assign at = atan_entry(cmd.step);

  always_ff @(posedge clk) begin
    if (cmd.angle) begin
      cx <= CORDIC_GAIN;
      cy <= '0;
      cz <= ang_round[50:18];
    end else if (cmd.rotate) begin
      if (!cz[32]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end
    end
  end

  // split distance: low part unsigned, high part signed
  assign op_a  = cmd.prod_hi ? distance[44:22] : $signed({1'b0, distance[21:0]});
  assign mul_x = op_a * cy;
  assign mul_y = op_a * cx;
  assign rnd_x = plo_x + 56'sd536870912;
  assign rnd_y = plo_y + 56'sd536870912;
  assign s_x   = phi_x + t_x;
  assign s_y   = phi_y + t_y;
  assign acc_x = pos_x + q_x;
  assign acc_y = pos_y + q_y;

  always_ff @(posedge clk) begin
    if (cmd.prod_lo) begin
      plo_x <= mul_x;
      plo_y <= mul_y;
    end
    if (cmd.prod_hi) begin
      phi_x <= mul_x;
      phi_y <= mul_y;
      t_x   <= rnd_x[55:22];
      t_y   <= rnd_y[55:22];
    end
    if (cmd.prod_sum) begin
      q_x <= s_x[56:8];
      q_y <= s_y[56:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left    <= '0;
      prev_right   <= '0;
      pos_x        <= '0;
      pos_y        <= '0;
      held_heading <= '0;
    end else if (cmd.accum) begin
      pos_x        <= sat40(acc_x);
      pos_y        <= sat40(acc_y);
      prev_left    <= req_left;
      prev_right   <= req_right;
      held_heading <= req_heading;
    end else if (cmd.apply) begin
      unique case (req_mode)
        MODE_ORIGIN: begin
          prev_left  <= '0;
          prev_right <= '0;
          pos_x      <= '0;
          pos_y      <= '0;
        end
        MODE_SET: begin
          pos_x <= req_new_x;
          pos_y <= req_new_y;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_x <= pos_x;
      out_y <= pos_y;
      out_h <= held_heading;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {out_h, out_y, out_x};

endmodule
`default_nettype wire

[test/differential_drive_odometry_tb.sv]
// Testbench for the dead-reckoning odometry block: random and directed requests, self-checked.
`timescale 1ns / 100ps
`default_nettype none
module differential_drive_odometry_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STEPS = 24;
  localparam longint TURN_Q8 = 92160;
  localparam longint HALF_Q8 = 46080;
  localparam longint QUARTER_Q8 = 23040;
  localparam longint RAD_PER_DEG_Q40 = 64'sd19190098068;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint POS_TOP = 64'sd549755813887;
  localparam longint POS_BOTTOM = -64'sd549755813888;
  localparam logic [39:0] COORD_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] COORD_MIN = 40'h80_0000_0000;

  class odometry_board;
    longint scale = 258830;
    longint last_left = 0;
    longint last_right = 0;
    longint x_pos = 0;
    longint y_pos = 0;
    longint bearing = 0;
    int errors = 0;
    logic [111:0] due_q[$];

    function longint arc_q30(input int i);
      case (i)
        0: return 843314857;
        1: return 497837829;
        2: return 263043837;
        3: return 133525159;
        4: return 67021687;
        5: return 33543516;
        6: return 16775851;
        7: return 8388437;
        8: return 4194283;
        9: return 2097149;
        default: return (i <= 30) ? (longint'(1) << (30 - i)) : 0;
      endcase
    endfunction

    function void bearing_sincos(input longint h, output longint sn, output longint cs);
      longint m;
      longint z;
      longint x;
      longint y;
      longint xs;
      longint ys;
      bit flip;
      int i;
      flip = 1'b0;
      m = h % TURN_Q8;
      if (m < 0) m += TURN_Q8;
      if (m > HALF_Q8) m -= TURN_Q8;
      if (m > QUARTER_Q8) begin
        m -= HALF_Q8;
        flip = 1'b1;
      end else if (m < -QUARTER_Q8) begin
        m += HALF_Q8;
        flip = 1'b1;
      end
      z = (m * RAD_PER_DEG_Q40 + 131072) >>> 18;
      x = GAIN_Q30;
      y = 0;
      for (i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= arc_q30(i);
        end else begin
          x += ys;
          y -= xs;
          z += arc_q30(i);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      sn = y;
      cs = x;
    endfunction

    function longint advance(input longint pos, input longint d, input longint s);
      logic signed [127:0] wide;
      longint v;
      wide = d * s;
      wide = (wide + 128'sd536870912) >>> 30;
      v = pos + longint'(wide);
      if (v > POS_TOP) v = POS_TOP;
      if (v < POS_BOTTOM) v = POS_BOTTOM;
      return v;
    endfunction

    function void note_request(input logic [1:0] mode, input logic [175:0] data);
      longint l;
      longint r;
      longint h;
      longint d;
      longint sn;
      longint cs;
      logic [111:0] e;
      l = longint'($signed(data[31:0]));
      r = longint'($signed(data[63:32]));
      h = longint'($signed(data[95:64]));
      case (mode)
        ddo_pkg::MODE_SAMPLE: begin
          d = (((l - last_left) + (r - last_right)) * scale + 4096) >>> 13;
          bearing_sincos(h, sn, cs);
          x_pos = advance(x_pos, d, sn);
          y_pos = advance(y_pos, d, cs);
          last_left = l;
          last_right = r;
          bearing = h;
        end
        ddo_pkg::MODE_ORIGIN: begin
          last_left = 0;
          last_right = 0;
          x_pos = 0;
          y_pos = 0;
        end
        ddo_pkg::MODE_SET: begin
          x_pos = longint'($signed(data[135:96]));
          y_pos = longint'($signed(data[175:136]));
        end
        default: ;
      endcase
      e[39:0] = x_pos[39:0];
      e[79:40] = y_pos[39:0];
      e[111:80] = bearing[31:0];
      due_q.push_back(e);
    endfunction

    function void check_result(input logic [111:0] got);
      logic [111:0] e;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting, got %h", $time, got);
        return;
      end
      e = due_q.pop_front();
      if (got[39:0] !== e[39:0]) begin
        errors++;
        $display("%0t: x_position expected %0d got %0d", $time,
                 $signed(e[39:0]), $signed(got[39:0]));
      end
      if (got[79:40] !== e[79:40]) begin
        errors++;
        $display("%0t: y_position expected %0d got %0d", $time,
                 $signed(e[79:40]), $signed(got[79:40]));
      end
      if (got[111:80] !== e[111:80]) begin
        errors++;
        $display("%0t: last_heading expected %0d got %0d", $time,
                 $signed(e[111:80]), $signed(got[111:80]));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [23:0] cfg_wdata;
  logic s_tvalid;
  logic s_tready;
  logic [175:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [111:0] m_tdata;

  odometry_board board = new();
  int send_idle_pct;
  int recv_stall_pct;
  int gen_left;
  int gen_right;
  int gen_heading;

  differential_drive_odometry dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if (s_tvalid && s_tready) board.note_request(s_tuser, s_tdata);
    end
  end

  task automatic send_request(input logic [1:0] mode, input logic [31:0] l,
                              input logic [31:0] r, input logic [31:0] h,
                              input logic [39:0] nx, input logic [39:0] ny);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tuser <= mode;
    s_tdata <= {ny, nx, h, r, l};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic write_scale(input logic [23:0] v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.scale = longint'(v);
  endtask

  function automatic logic [39:0] pick_coord();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return w[39:0];
      default: return 40'(longint'($urandom_range(1 << 27)) - (1 << 26));
    endcase
  endfunction

  task automatic send_random();
    int roll;
    logic [63:0] jx;
    logic [63:0] jy;
    roll = $urandom_range(99);
    jx = {$urandom, $urandom};
    jy = {$urandom, $urandom};
    if (roll < 3) begin
      gen_left = 0;
      gen_right = 0;
      send_request(ddo_pkg::MODE_ORIGIN, $urandom, $urandom, $urandom, jx[39:0], jy[39:0]);
    end else if (roll < 8) begin
      send_request(ddo_pkg::MODE_SET, $urandom, $urandom, $urandom, pick_coord(), pick_coord());
    end else if (roll < 10) begin
      send_request(MODE_UNUSED, $urandom, $urandom, $urandom, jx[39:0], jy[39:0]);
    end else begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        gen_left = gen_left + int'($urandom_range(4000)) - 2000;
        gen_right = gen_right + int'($urandom_range(4000)) - 2000;
        gen_heading = gen_heading + int'($urandom_range(2560)) - 1280;
      end else if (roll < 90) begin
        gen_left = int'($urandom);
        gen_right = int'($urandom);
        gen_heading = int'($urandom);
      end else begin
        gen_left = gen_left + int'($urandom_range(40000)) - 20000;
        gen_right = gen_right + int'($urandom_range(40000)) - 20000;
        gen_heading = 23040 * (int'($urandom_range(16)) - 8) + int'($urandom_range(4)) - 2;
      end
      send_request(ddo_pkg::MODE_SAMPLE, gen_left, gen_right, gen_heading, jx[39:0], jy[39:0]);
    end
  endtask

  task automatic run_directed();
    send_request(ddo_pkg::MODE_SAMPLE, 0, 0, 0, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 1600, 1600, 0, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 3200, 3200, 23040, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 4800, 4800, 46080, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 6400, 6400, -23040, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 8000, 8000, -46080, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 9600, 9600, 92160, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 11200, 12800, 69120, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 12800, 14400, 32'h7FFF_FFFF, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 14400, 16000, 32'h8000_0000, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 11520, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 32'h8000_0000, 32'h8000_0000, -11520, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 5760, '0, '0);
    send_request(ddo_pkg::MODE_SET, 0, 0, 0, COORD_MAX, COORD_MIN);
    send_request(ddo_pkg::MODE_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 23040, '0, '0);
    send_request(ddo_pkg::MODE_SAMPLE, 32'h8000_0000, 32'h8000_0000, 0, '0, '0);
    send_request(ddo_pkg::MODE_SET, 0, 0, 0, COORD_MIN, COORD_MAX);
    send_request(ddo_pkg::MODE_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -11520, '0, '0);
    send_request(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1);
    send_request(ddo_pkg::MODE_ORIGIN, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, '1, '1);
    send_request(ddo_pkg::MODE_SAMPLE, 160, 320, 2560, '0, '0);
    send_request(ddo_pkg::MODE_SET, 0, 0, 0, '0, '0);
    send_request(MODE_UNUSED, 0, 0, 0, '0, '0);
  endtask

  initial begin
    #4_000_000;
    $display("differential_drive_odometry_tb: FAIL");
    $finish;
  end

  initial begin
    logic [23:0] scale_set [6];
    int phase;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ddo_pkg::MODE_SAMPLE;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    gen_left = 0;
    gen_right = 0;
    gen_heading = 0;
    scale_set[0] = ddo_pkg::IPD_RESET;
    scale_set[1] = 24'd0;
    scale_set[2] = 24'hFF_FFFF;
    scale_set[3] = 24'($urandom_range(24'hFF_FFFF));
    scale_set[4] = 24'd1;
    scale_set[5] = 24'($urandom_range(24'hFF_FFFF));
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    for (phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        drain();
        write_scale(scale_set[phase]);
      end
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 80;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 80;
        end
        default: begin
          send_idle_pct = 19;
          recv_stall_pct = 19;
        end
      endcase
      repeat (110) send_random();
    end
    drain();
    if (board.errors == 0) begin
      $display("differential_drive_odometry_tb: PASS");
    end else begin
      $display("differential_drive_odometry_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
